FILE: rtl/core/morse_key_timing_decoder_unit_macros.svh
// Assertion helpers for the Morse key timing decoder.
`ifndef MORSE_KEY_TIMING_DECODER_UNIT_MACROS_SVH
`define MORSE_KEY_TIMING_DECODER_UNIT_MACROS_SVH

// Check a condition at every clock edge.
`define MKTD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define MKTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the following cycle.
`define MKTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mktd_pkg.sv
package mktd_pkg;

  localparam int unsigned CODE_CAPACITY_DEF = 8;
  localparam int unsigned DIT_W             = 10;
  localparam int unsigned DIT_MUL_W         = DIT_W + 3;
  localparam int unsigned TIME_W            = 31;
  localparam int unsigned CHAR_W            = 7;
  localparam int unsigned ADDR_W            = 3;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned MAX_CODE_LEN      = 6;

  localparam logic [DIT_W-1:0]  DIT_DEFAULT  = 10'd66;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd63;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;

  localparam logic REG_DIT_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    REQ_KEY   = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } result_t;

  // Element k of the code is bit k of pat, 1 for a dash.
  function automatic logic [CHAR_W-1:0] code_lookup(input logic [5:0] pat,
                                                    input logic [2:0] len);
    logic [CHAR_W-1:0] ch;
    case ({len, pat})
      {3'd6, 6'd53}: ch = 7'd33;
      {3'd6, 6'd18}: ch = 7'd34;
      {3'd5, 6'd2}:  ch = 7'd38;
      {3'd6, 6'd30}: ch = 7'd39;
      {3'd5, 6'd13}: ch = 7'd40;
      {3'd6, 6'd45}: ch = 7'd41;
      {3'd5, 6'd10}: ch = 7'd43;
      {3'd6, 6'd51}: ch = 7'd44;
      {3'd6, 6'd33}: ch = 7'd45;
      {3'd6, 6'd42}: ch = 7'd46;
      {3'd5, 6'd9}:  ch = 7'd47;
      {3'd5, 6'd31}: ch = 7'd48;
      {3'd5, 6'd30}: ch = 7'd49;
      {3'd5, 6'd28}: ch = 7'd50;
      {3'd5, 6'd24}: ch = 7'd51;
      {3'd5, 6'd16}: ch = 7'd52;
      {3'd5, 6'd0}:  ch = 7'd53;
      {3'd5, 6'd1}:  ch = 7'd54;
      {3'd5, 6'd3}:  ch = 7'd55;
      {3'd5, 6'd7}:  ch = 7'd56;
      {3'd5, 6'd15}: ch = 7'd57;
      {3'd6, 6'd7}:  ch = 7'd58;
      {3'd6, 6'd21}: ch = 7'd59;
      {3'd5, 6'd17}: ch = 7'd61;
      {3'd6, 6'd12}: ch = 7'd63;
      {3'd6, 6'd22}: ch = 7'd64;
      {3'd2, 6'd2}:  ch = 7'd65;
      {3'd4, 6'd1}:  ch = 7'd66;
      {3'd4, 6'd5}:  ch = 7'd67;
      {3'd3, 6'd1}:  ch = 7'd68;
      {3'd1, 6'd0}:  ch = 7'd69;
      {3'd4, 6'd4}:  ch = 7'd70;
      {3'd3, 6'd3}:  ch = 7'd71;
      {3'd4, 6'd0}:  ch = 7'd72;
      {3'd2, 6'd0}:  ch = 7'd73;
      {3'd4, 6'd14}: ch = 7'd74;
      {3'd3, 6'd5}:  ch = 7'd75;
      {3'd4, 6'd2}:  ch = 7'd76;
      {3'd2, 6'd3}:  ch = 7'd77;
      {3'd2, 6'd1}:  ch = 7'd78;
      {3'd3, 6'd7}:  ch = 7'd79;
      {3'd4, 6'd6}:  ch = 7'd80;
      {3'd4, 6'd11}: ch = 7'd81;
      {3'd3, 6'd2}:  ch = 7'd82;
      {3'd3, 6'd0}:  ch = 7'd83;
      {3'd1, 6'd1}:  ch = 7'd84;
      {3'd3, 6'd4}:  ch = 7'd85;
      {3'd4, 6'd8}:  ch = 7'd86;
      {3'd3, 6'd6}:  ch = 7'd87;
      {3'd4, 6'd9}:  ch = 7'd88;
      {3'd4, 6'd13}: ch = 7'd89;
      {3'd4, 6'd3}:  ch = 7'd90;
      default:       ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/core/morse_key_timing_decoder_unit.sv
// Latency: a result is offered on the output the cycle after its input transfer.
// Throughput: one input item per cycle while the output is unstalled and each item
// yields at most one result; a word space and a character hold the next item until
// the two-entry buffer, draining one result per unstalled cycle, holds one result.
// Reset: asynchronous, active low; clears all timing and code state, empties the
// result buffer and sets the dit length to 66 ms.
module morse_key_timing_decoder_unit #(
  parameter int unsigned CODE_CAPACITY = mktd_pkg::CODE_CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic                          key_down_i,
  input  logic [mktd_pkg::TIME_W-1:0]   time_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mktd_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mktd_pkg::ADDR_W-1:0]   paddr,
  input  logic [mktd_pkg::DATA_W-1:0]   pwdata,
  output logic [mktd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mktd_pkg::*;

  localparam int unsigned BITS_W = CODE_CAPACITY - 1;
  localparam int unsigned CNT_W  = $clog2(CODE_CAPACITY);

  logic [DIT_W-1:0]     dit_q;
  logic [DIT_MUL_W-1:0] dit2_q, dit3_q, dit7_q;
  logic [DIT_W-1:0]     dit_new;
  logic                 cfg_we;

  logic [TIME_W-1:0] press_time_q, press_time_d;
  logic [TIME_W-1:0] release_time_q, release_time_d;
  logic [TIME_W-1:0] latest_q, latest_d;
  logic              press_open_q, press_open_d;
  logic              release_open_q, release_open_d;
  logic [BITS_W-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              space_q, space_d;

  result_t    buf_q [2];
  logic [1:0] fill_q;
  result_t    res0, res1;
  logic [1:0] res_n;

  logic              accept, drain;
  logic [TIME_W-1:0] t_clamp, gap, hold;
  logic              gap3, gap7, dash, gap_check, flush;
  logic [CHAR_W-1:0] code_char;

  assign cfg_we  = psel & penable & pwrite & (paddr[ADDR_W-1] == REG_DIT_LENGTH);
  assign dit_new = (pwdata[DIT_W-1:0] == '0) ? DIT_DEFAULT : pwdata[DIT_W-1:0];
  assign pready  = 1'b1;
  assign prdata  = (paddr[ADDR_W-1] == REG_DIT_LENGTH) ?
                   {{(DATA_W-DIT_W){1'b0}}, dit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_q  <= DIT_DEFAULT;
      dit2_q <= DIT_MUL_W'(DIT_DEFAULT) << 1;
      dit3_q <= (DIT_MUL_W'(DIT_DEFAULT) << 1) + DIT_MUL_W'(DIT_DEFAULT);
      dit7_q <= (DIT_MUL_W'(DIT_DEFAULT) << 3) - DIT_MUL_W'(DIT_DEFAULT);
    end else if (cfg_we) begin
      dit_q  <= dit_new;
      dit2_q <= DIT_MUL_W'(dit_new) << 1;
      dit3_q <= (DIT_MUL_W'(dit_new) << 1) + DIT_MUL_W'(dit_new);
      dit7_q <= (DIT_MUL_W'(dit_new) << 3) - DIT_MUL_W'(dit_new);
    end
  end

  assign out_valid_o = (fill_q != 2'd0);
  assign character_o = buf_q[0].character;
  assign last_o      = buf_q[0].last;
  assign drain       = out_valid_o & ~out_stall_i;
  assign in_stall_o  = (fill_q == 2'd2) | ((fill_q == 2'd1) & out_stall_i);
  assign accept      = in_valid_i & ~in_stall_o;

  assign t_clamp = (time_ms_i < latest_q) ? latest_q : time_ms_i;
  assign gap     = t_clamp - release_time_q;
  assign hold    = t_clamp - press_time_q;
  assign gap3    = gap >= TIME_W'(dit3_q);
  assign gap7    = gap >= TIME_W'(dit7_q);
  assign dash    = hold >= TIME_W'(dit2_q);

  assign code_char = (cnt_q > CNT_W'(MAX_CODE_LEN)) ? CHAR_UNKNOWN :
                     code_lookup(bits_q[5:0], cnt_q[2:0]);

  always_comb begin
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    latest_d       = latest_q;
    press_open_d   = press_open_q;
    release_open_d = release_open_q;
    bits_d         = bits_q;
    cnt_d          = cnt_q;
    gap_check      = 1'b0;
    case (req_type_i)
      REQ_KEY: begin
        latest_d = t_clamp;
        if (key_down_i) begin
          gap_check      = release_open_q;
          press_time_d   = t_clamp;
          press_open_d   = 1'b1;
          release_open_d = 1'b0;
        end else if (press_open_q) begin
          press_open_d   = 1'b0;
          release_time_d = t_clamp;
          release_open_d = 1'b1;
          if (cnt_q < CNT_W'(BITS_W)) begin
            bits_d = bits_q | (BITS_W'(dash) << cnt_q);
            cnt_d  = cnt_q + 1'b1;
          end
        end
      end
      REQ_TICK: begin
        latest_d  = t_clamp;
        gap_check = ~press_open_q & release_open_q;
      end
      REQ_CLEAR: begin
        latest_d       = t_clamp;
        bits_d         = '0;
        cnt_d          = '0;
        press_open_d   = 1'b0;
        release_open_d = 1'b0;
      end
      default: begin
      end
    endcase
    flush = gap_check & gap3 & (cnt_q != '0);
    if (flush) begin
      bits_d = '0;
      cnt_d  = '0;
    end
    space_d = (space_q & ~flush) | (gap_check & gap7);
  end

  always_comb begin
    res0  = '{character: code_char, last: 1'b1};
    res1  = '{character: code_char, last: 1'b1};
    res_n = 2'd0;
    if (flush) begin
      if (space_q) begin
        res0  = '{character: CHAR_SPACE, last: 1'b0};
        res_n = 2'd2;
      end else begin
        res_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_time_q   <= '0;
      release_time_q <= '0;
      latest_q       <= '0;
      press_open_q   <= 1'b0;
      release_open_q <= 1'b0;
      bits_q         <= '0;
      cnt_q          <= '0;
      space_q        <= 1'b0;
    end else if (accept) begin
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      latest_q       <= latest_d;
      press_open_q   <= press_open_d;
      release_open_q <= release_open_d;
      bits_q         <= bits_d;
      cnt_q          <= cnt_d;
      space_q        <= space_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else if (accept) begin
      fill_q <= res_n;
    end else if (drain) begin
      fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q[0] <= res0;
      buf_q[1] <= res1;
    end else if (drain) begin
      buf_q[0] <= buf_q[1];
    end
  end

`include "morse_key_timing_decoder_unit_macros.svh"

  `MKTD_ASSERT(a_open_excl, !(press_open_q && release_open_q), "press and release both open")
  `MKTD_ASSERT_IMPL(a_accept_room, accept, (fill_q == 2'd0) || ((fill_q == 2'd1) && drain), "transfer with results still held")
  `MKTD_ASSERT_IMPL(a_space_first, out_valid_o && !last_o, (fill_q == 2'd2) && buf_q[1].last, "word space without character")
  `MKTD_ASSERT_NEXT(a_dit_zero, cfg_we && (pwdata[DIT_W-1:0] == '0), dit_q == DIT_DEFAULT, "zero dit length not replaced")

endmodule

FILE: test/morse_key_timing_decoder_unit_tb.sv
module morse_key_timing_decoder_unit_tb;
  import mktd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TABLE_LEN = 58;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] DIT_ADDR = {REG_DIT_LENGTH, 2'b00};
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Entry i decodes to ASCII 33 + i; empty entries never match.
  string morse_codes [TABLE_LEN] = '{
    "-.-.--", ".-..-.", "", "", "", ".-...", ".----.", "-.--.",
    "-.--.-", "", ".-.-.", "--..--", "-....-", ".-.-.-", "-..-.", "-----",
    ".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
    "----.", "---...", "-.-.-.", "", "-...-", "", "..--..", ".--.-.",
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
    "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
    "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
    "-.--", "--.."
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          req_type_i;
  logic                key_down_i;
  logic [TIME_W-1:0]   time_ms_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CHAR_W-1:0]   character_o;
  logic                last_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [DIT_W-1:0]    dit_len = DIT_DEFAULT;
  logic [TIME_W-1:0]   press_at = '0;
  logic [TIME_W-1:0]   release_at = '0;
  logic [TIME_W-1:0]   latest_ms = '0;
  bit                  press_held = 1'b0;
  bit                  release_seen = 1'b0;
  bit                  word_space = 1'b0;
  logic [6:0]          code_bits = '0;
  int unsigned         code_len = 0;
  result_t             pending_chars [$];

  int unsigned         errors = 0;
  int unsigned         items_sent = 0;
  int unsigned         cycle_count = 0;
  int unsigned         stall_left = 0;
  bit                  calm = 1'b0;

  morse_key_timing_decoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .key_down_i  (key_down_i),
    .time_ms_i   (time_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] match_code();
    string pat;
    bit hit;
    for (int i = 0; i < TABLE_LEN; i++) begin
      pat = morse_codes[6'(i)];
      if (code_len > 0 && pat.len() == code_len) begin
        hit = 1'b1;
        for (int k = 0; k < pat.len(); k++) begin
          if ((pat[k] == "-") != code_bits[3'(k)]) hit = 1'b0;
        end
        if (hit) return CHAR_W'(33 + i);
      end
    end
    return CHAR_UNKNOWN;
  endfunction

  function automatic void flush_code();
    logic [CHAR_W-1:0] ch;
    if (code_len == 0) return;
    ch = match_code();
    code_len = 0;
    code_bits = '0;
    if (word_space) begin
      pending_chars.push_back('{character: CHAR_SPACE, last: 1'b0});
      word_space = 1'b0;
    end
    pending_chars.push_back('{character: ch, last: 1'b1});
  endfunction

  function automatic void close_gap(input logic [TIME_W-1:0] now_ms);
    int unsigned gap;
    gap = 32'(now_ms - release_at);
    if (gap >= 32'd3 * dit_len) flush_code();
    if (gap >= 32'd7 * dit_len) word_space = 1'b1;
  endfunction

  function automatic void predict_characters(input logic [1:0] kind, input logic down,
                                             input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] now_ms;
    int unsigned held;
    now_ms = (t < latest_ms) ? latest_ms : t;
    case (kind)
      REQ_KEY: begin
        latest_ms = now_ms;
        if (down) begin
          if (release_seen) close_gap(now_ms);
          press_at = now_ms;
          press_held = 1'b1;
          release_seen = 1'b0;
        end else if (press_held) begin
          held = 32'(now_ms - press_at);
          press_held = 1'b0;
          release_at = now_ms;
          release_seen = 1'b1;
          if (code_len < CODE_CAPACITY_DEF - 1) begin
            code_bits[3'(code_len)] = (held >= 32'd2 * dit_len);
            code_len++;
          end
        end
      end
      REQ_TICK: begin
        latest_ms = now_ms;
        if (!press_held && release_seen) close_gap(now_ms);
      end
      REQ_CLEAR: begin
        code_bits = '0;
        code_len = 0;
        press_held = 1'b0;
        release_seen = 1'b0;
        latest_ms = now_ms;
      end
      default: ;
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual character %0d last %0b",
                 $time, character_o, last_o);
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.character) begin
          errors++;
          $display("%0t: character expected %0d actual %0d", $time, want.character,
                   character_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
        end
      end
      stall_left = calm ? 0 : $urandom_range(9, 0);
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic down,
                            input logic [TIME_W-1:0] t);
    int unsigned idle;
    idle = calm ? 0 : $urandom_range(9, 0);
    @(negedge clk_i);
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    key_down_i <= down;
    time_ms_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    predict_characters(kind, down, t);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  task automatic key_at(input logic down, input int unsigned delta);
    send_event(REQ_KEY, down, TIME_W'(latest_ms + delta));
  endtask

  // Drop valid and hold until every expected transfer has arrived.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= DIT_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_dit_readback();
    logic [DATA_W-1:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback !== DATA_W'(dit_len)) begin
      errors++;
      $display("%0t: dit_length read expected %0d actual %0d", $time, dit_len, readback);
    end
  endtask

  task automatic program_dit(input logic [DIT_W-1:0] value);
    logic [DATA_W-1:0] unused;
    wait_idle();
    apb_access(1'b1, DATA_W'(value), unused);
    dit_len = (value == '0) ? DIT_DEFAULT : value;
    check_dit_readback();
  endtask

  // Random span from lo dits to just below hi dits, edges favored.
  function automatic int unsigned span(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(3, 0))
      0: return lo * dit_len;
      1: return hi * dit_len - 1;
      default: return $urandom_range(hi * dit_len - 1, lo * dit_len);
    endcase
  endfunction

  task automatic send_char(input int unsigned lead);
    int unsigned len;
    len = ($urandom_range(9, 0) == 0) ? $urandom_range(9, 7) : $urandom_range(6, 1);
    for (int e = 0; e < len; e++) begin
      key_at(1'b1, (e == 0) ? lead : span(0, 3));
      key_at(1'b0, $urandom_range(1, 0) ? span(0, 2) : span(2, 5));
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(5, 0))
      0: send_event(REQ_CLEAR, 1'($urandom_range(1, 0)), $urandom_range(1, 0) ?
                    TIME_W'(latest_ms + span(0, 7)) : TIME_W'($urandom_range(latest_ms, 0)));
      1: send_event(REQ_UNUSED, 1'($urandom_range(1, 0)), TIME_W'($urandom));
      2: key_at(1'b0, span(0, 3));
      3: send_event(REQ_TICK, 1'($urandom_range(1, 0)),
                    TIME_W'($urandom_range(latest_ms, 0)));
      4: send_event(REQ_KEY, 1'b1, TIME_W'($urandom_range(latest_ms, 0)));
      default: key_at(1'b1, span(0, 3));
    endcase
  endtask

  task automatic run_traffic(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(9, 0))
        0, 1: send_noise();
        2: send_event(REQ_TICK, 1'($urandom_range(1, 0)),
                      TIME_W'(latest_ms + span(3, 12)));
        default: begin
          case ($urandom_range(2, 0))
            0: send_char(span(0, 3));
            1: send_char(span(3, 7));
            default: send_char(span(7, 12));
          endcase
        end
      endcase
    end
  endtask

  task automatic test_directed_sequence();
    check_dit_readback();
    send_event(REQ_KEY, 1'b0, TIME_W'(0));
    send_event(REQ_TICK, 1'b1, TIME_W'(5));
    send_event(REQ_KEY, 1'b1, TIME_W'(10));
    send_event(REQ_KEY, 1'b1, TIME_W'(20));
    send_event(REQ_KEY, 1'b0, TIME_W'(151));
    send_event(REQ_KEY, 1'b1, TIME_W'(100));
    send_event(REQ_KEY, 1'b0, TIME_W'(283));
    send_event(REQ_TICK, 1'b0, TIME_W'(480));
    send_event(REQ_TICK, 1'b0, TIME_W'(481));
    wait_idle();
    send_event(REQ_TICK, 1'b1, TIME_W'(745));
    send_event(REQ_KEY, 1'b1, TIME_W'(800));
    send_event(REQ_TICK, 1'b0, TIME_W'(900));
    send_event(REQ_KEY, 1'b0, TIME_W'(910));
    send_event(REQ_CLEAR, 1'b1, TIME_W'(950));
    send_event(REQ_UNUSED, 1'b1, TIME_MAX);
  endtask

  task automatic test_code_full();
    for (int e = 0; e < CODE_CAPACITY_DEF; e++) begin
      key_at(1'b1, 10);
      key_at(1'b0, span(0, 5));
    end
    send_event(REQ_TICK, 1'b0, TIME_W'(latest_ms + span(3, 7)));
  endtask

  task automatic test_dit_extremes();
    logic [DIT_W-1:0] settings [3];
    settings = '{10'd1, 10'd1023, 10'd0};
    foreach (settings[i]) begin
      program_dit(settings[i]);
      run_traffic(50);
    end
  endtask

  task automatic test_random_traffic();
    program_dit(DIT_W'($urandom_range(120, 2)));
    run_traffic(80);
    program_dit(DIT_W'($urandom_range(1023, 1)));
    calm = 1'b1;
    run_traffic(80);
    calm = 1'b0;
    program_dit(DIT_W'($urandom_range(40, 1)));
    run_traffic(80);
  endtask

  task automatic test_time_limits();
    program_dit(10'd1);
    send_event(REQ_KEY, 1'b1, TIME_W'(TIME_MAX - 20));
    send_event(REQ_KEY, 1'b0, TIME_W'(TIME_MAX - 10));
    send_event(REQ_TICK, 1'b0, TIME_MAX);
    repeat (10) begin
      send_event(2'($urandom_range(2, 0)), 1'($urandom_range(1, 0)), TIME_W'($urandom));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_KEY;
    key_down_i  = 1'b0;
    time_ms_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_sequence();
    test_code_full();
    test_dit_extremes();
    test_random_traffic();
    test_time_limits();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
